// ----- rtl/qif_pkg.sv -----
// Package for the quaternion IMU fusion step: item structs, lane structs,
// sequencer states, register indexes, the reciprocal-root seed table and helpers.
// Depends on nothing.
package qif_pkg;

    localparam int NLANE = 4;

    localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
    localparam logic [33:0]        THREE_Q30 = 34'd3221225472;
    localparam logic [32:0]        Y_MAX     = 33'h0_8000_0000;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] att_w;
        logic signed [31:0] att_x;
        logic signed [31:0] att_y;
        logic signed [31:0] att_z;
    } t_out_item;

    typedef struct packed {
        logic [32:0] a;
        logic [32:0] b;
        logic        neg;
    } t_lane_in;

    typedef struct packed {
        logic [65:0] p;
        logic        neg;
    } t_lane_out;

    typedef logic signed [69:0] t_term;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_NORM, ST_NR1, ST_NR2, ST_NR3, ST_UNIT,
        ST_TQ, ST_RQ, ST_ERR, ST_RATE, ST_HDT, ST_SQ0, ST_PQ, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        CFG_GRAV_X, CFG_GRAV_Y, CFG_GRAV_Z, CFG_HALF_DT, CFG_GAIN
    } t_cfg_idx;

    localparam logic [31:0] SEED [8] = '{
        32'd1920767367, 32'd1920767367, 32'd1920767367, 32'd1623345166,
        32'd1431655765, 32'd1294980959, 32'd1191209179, 32'd1108956259
    };

    function automatic logic [31:0] f_mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] f_sat32(input t_term v);
        if (v > 70'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -70'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/qif_lane.sv -----
// One multiplier lane: a registered sign-magnitude product of two operands.
// Depends on qif_pkg.
module qif_lane import qif_pkg::*; (
    input  logic      i_clk,
    input  t_lane_in  i_op,
    output t_lane_out o_res
);

    t_lane_out r_res;

    always_ff @(posedge i_clk) begin
        r_res.p   <= i_op.a * i_op.b;
        r_res.neg <= i_op.neg;
    end

    assign o_res = r_res;

endmodule

// ----- rtl/qif_merge.sv -----
// Merging stage: shifts each lane product to its format, applies its sign and sums
// the lanes. Depends on qif_pkg.
module qif_merge import qif_pkg::*; (
    input  t_lane_out   i_lanes [NLANE],
    input  logic [5:0]  i_sh,
    output t_term       o_term [NLANE],
    output t_term       o_sum
);

    logic [65:0] shv [NLANE];

    always_comb begin
        o_sum = '0;
        for (int l = 0; l < NLANE; l++) begin
            shv[l]    = i_lanes[l].p >> i_sh;
            o_term[l] = i_lanes[l].neg ? -$signed({4'b0, shv[l]}) : $signed({4'b0, shv[l]});
            o_sum     = o_sum + o_term[l];
        end
    end

endmodule

// ----- rtl/quaternion_imu_fusion_step.sv -----
// Top level of the quaternion IMU fusion step: sequencer, four multiplier lanes
// and the merging stage. Depends on qif_pkg, qif_lane and qif_merge.
//
// One item at a time is processed. Each sum of squares, of the acceleration and of the
// attitude product, is normalized by two-bit shifts: up to 15 for the acceleration and
// up to 31 for the attitude product, usually one or two each. A zero acceleration or a
// zero attitude product skips that normalization and its Newton steps. The work is
// paced by the four shared multiplier lanes, each product passing an issue and a collect
// phase, and by the dependent products of the Newton iterations. A finished attitude
// waits in the output register while the next item is already being worked on.
module quaternion_imu_fusion_step import qif_pkg::*; #(
    parameter int NEWTON_STEPS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NW = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;
    localparam logic [NW-1:0] NR_LAST = NW'(NEWTON_STEPS - 1);

    localparam logic [1:0] QA [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd0, 2'd3, 2'd1, 2'd2}};
    localparam logic [1:0] QB [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd0, 2'd3, 2'd1}, '{2'd3, 2'd0, 2'd2, 2'd1}};
    localparam logic QS [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b1}};
    localparam logic [1:0] EU [3][2] = '{'{2'd1, 2'd2}, '{2'd2, 2'd0}, '{2'd0, 2'd1}};
    localparam logic [1:0] ER [3][2] = '{'{2'd3, 2'd2}, '{2'd1, 2'd3}, '{2'd2, 2'd1}};

    t_state r_state, n_state;
    logic   r_ph, n_ph;
    logic [1:0] r_idx, n_idx;

    logic signed [31:0] r_grav [3];
    logic [30:0] r_hdt;
    logic [3:0]  r_gain;

    logic signed [15:0] r_acc  [3];
    logic signed [31:0] r_rate [3];
    logic signed [31:0] r_ua   [3];
    logic signed [31:0] r_err  [3];
    logic signed [31:0] r_w    [3];
    logic signed [31:0] r_t    [4];
    logic signed [31:0] r_r    [4];
    logic signed [31:0] r_sq   [4];
    logic signed [31:0] r_prod [4];
    logic signed [31:0] r_q    [4];
    logic        r_vq;
    logic [NW-1:0] r_nr;
    logic [4:0]  r_c;
    logic [63:0] r_norm;
    logic [31:0] r_y;
    logic [32:0] r_y2;
    logic [31:0] r_d;
    t_out_item   r_out;
    logic        r_ovalid;

    t_lane_in  lane_in  [NLANE];
    t_lane_out lane_out [NLANE];
    t_term     mg_term  [NLANE];
    t_term     mg_sum;
    logic [5:0] mg_sh;

    logic [31:0] qa_mag [4];
    logic [31:0] qb_mag [4];
    logic        qa_neg [4];
    logic        qb_neg [4];

    logic        in_acc;
    logic        sq_zero;
    logic        out_load;
    logic [33:0] nr_t;
    logic [31:0] nr_d;
    logic [32:0] nr_y;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
    assign sq_zero     = (mg_sum == '0);
    assign out_load    = (r_state == ST_DONE) && (!r_ovalid || i_out_ready);
    assign nr_t        = mg_term[0][33:0];
    assign nr_d        = (nr_t > THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - nr_t);
    assign nr_y        = mg_term[0][32:0];

    for (genvar gl = 0; gl < NLANE; gl++) begin : g_lane
        qif_lane u_lane (
            .i_clk (i_clk),
            .i_op  (lane_in[gl]),
            .o_res (lane_out[gl])
        );
    end

    qif_merge u_merge (
        .i_lanes (lane_out),
        .i_sh    (mg_sh),
        .o_term  (mg_term),
        .o_sum   (mg_sum)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            case (r_state)
                ST_TQ: begin
                    qa_mag[i] = f_mag32(r_q[i]);
                    qa_neg[i] = (i == 0) ? r_q[i][31] : ~r_q[i][31];
                    qb_mag[i] = (i == 0) ? 32'd0 : f_mag32(r_grav[(i == 0) ? 0 : i - 1]);
                    qb_neg[i] = (i == 0) ? 1'b0 : r_grav[(i == 0) ? 0 : i - 1][31];
                end
                ST_RQ: begin
                    qa_mag[i] = f_mag32(r_t[i]);
                    qa_neg[i] = r_t[i][31];
                    qb_mag[i] = f_mag32(r_q[i]);
                    qb_neg[i] = r_q[i][31];
                end
                default: begin
                    qa_mag[i] = f_mag32(r_q[i]);
                    qa_neg[i] = r_q[i][31];
                    qb_mag[i] = f_mag32(r_sq[i]);
                    qb_neg[i] = r_sq[i][31];
                end
            endcase
        end

        for (int l = 0; l < NLANE; l++) begin
            lane_in[l] = '{a: 33'd0, b: 33'd0, neg: 1'b0};
            case (r_state)
                ST_SQ: begin
                    if (r_vq) begin
                        lane_in[l].a = {1'b0, f_mag32(r_prod[l])};
                        lane_in[l].b = {1'b0, f_mag32(r_prod[l])};
                    end else if (l < 3) begin
                        lane_in[l].a = {1'b0, f_mag32({{16{r_acc[l][15]}}, r_acc[l]})};
                        lane_in[l].b = {1'b0, f_mag32({{16{r_acc[l][15]}}, r_acc[l]})};
                    end
                end
                ST_NR1: begin
                    if (l == 0) begin
                        lane_in[l].a = {1'b0, r_y};
                        lane_in[l].b = {1'b0, r_y};
                    end
                end
                ST_NR2: begin
                    if (l == 0) begin
                        lane_in[l].a = {1'b0, r_norm[63:32]};
                        lane_in[l].b = r_y2;
                    end
                end
                ST_NR3: begin
                    if (l == 0) begin
                        lane_in[l].a = {1'b0, r_y};
                        lane_in[l].b = {1'b0, r_d};
                    end
                end
                ST_UNIT: begin
                    lane_in[l].b = {1'b0, r_y};
                    if (r_vq) begin
                        lane_in[l].a   = {1'b0, f_mag32(r_prod[l])};
                        lane_in[l].neg = r_prod[l][31];
                    end else if (l < 3) begin
                        lane_in[l].a   = {1'b0, f_mag32({{16{r_acc[l][15]}}, r_acc[l]})};
                        lane_in[l].neg = r_acc[l][15];
                    end
                end
                ST_TQ, ST_RQ, ST_PQ: begin
                    lane_in[l].a   = {1'b0, qa_mag[QA[r_idx][l]]};
                    lane_in[l].b   = {1'b0, qb_mag[QB[r_idx][l]]};
                    lane_in[l].neg = qa_neg[QA[r_idx][l]] ^ qb_neg[QB[r_idx][l]] ^ QS[r_idx][l];
                end
                ST_ERR: begin
                    if (l < 2 && r_idx != 2'd3) begin
                        lane_in[l].a   = {1'b0, f_mag32(r_ua[EU[r_idx][l]])};
                        lane_in[l].b   = {1'b0, f_mag32(r_r[ER[r_idx][l]])};
                        lane_in[l].neg = r_ua[EU[r_idx][l]][31] ^ r_r[ER[r_idx][l]][31]
                                         ^ (l == 1);
                    end
                end
                ST_RATE: begin
                    if (l < 3) begin
                        lane_in[l].a   = {1'b0, f_mag32(r_err[l])};
                        lane_in[l].b   = {29'd0, r_gain};
                        lane_in[l].neg = r_err[l][31];
                    end
                end
                ST_HDT: begin
                    if (l < 3) begin
                        lane_in[l].a   = {1'b0, f_mag32(r_w[l])};
                        lane_in[l].b   = {2'd0, r_hdt};
                        lane_in[l].neg = r_w[l][31];
                    end
                end
                ST_SQ0: begin
                    if (l < 3) begin
                        lane_in[l].a = {1'b0, f_mag32(r_sq[l + 1])};
                        lane_in[l].b = {1'b0, f_mag32(r_sq[l + 1])};
                    end
                end
                default: begin
                    lane_in[l] = '{a: 33'd0, b: 33'd0, neg: 1'b0};
                end
            endcase
        end

        case (r_state)
            ST_SQ:   mg_sh = r_vq ? 6'd2 : 6'd0;
            ST_NR1:  mg_sh = 6'd30;
            ST_NR2:  mg_sh = 6'd32;
            ST_NR3:  mg_sh = 6'd31;
            ST_UNIT: mg_sh = 6'd32 - {1'b0, r_c} + {5'd0, r_vq};
            ST_RATE: mg_sh = 6'd6;
            ST_HDT:  mg_sh = 6'd25;
            default: mg_sh = 6'd30;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SQ;
                    n_ph    = 1'b0;
                end
            end
            ST_NORM: begin
                if (r_norm[63:62] != 2'b00) begin
                    n_state = ST_NR1;
                    n_ph    = 1'b0;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    case (r_state)
                        ST_SQ: begin
                            n_idx = 2'd0;
                            if (sq_zero) begin
                                n_state = r_vq ? ST_DONE : ST_TQ;
                            end else begin
                                n_state = ST_NORM;
                            end
                        end
                        ST_NR1: n_state = ST_NR2;
                        ST_NR2: n_state = ST_NR3;
                        ST_NR3: n_state = (r_nr == NR_LAST) ? ST_UNIT : ST_NR1;
                        ST_UNIT: begin
                            n_idx   = 2'd0;
                            n_state = r_vq ? ST_DONE : ST_TQ;
                        end
                        ST_TQ: begin
                            n_idx = r_idx + 2'd1;
                            if (r_idx == 2'd3) begin
                                n_state = ST_RQ;
                            end
                        end
                        ST_RQ: begin
                            n_idx = r_idx + 2'd1;
                            if (r_idx == 2'd3) begin
                                n_state = ST_ERR;
                            end
                        end
                        ST_ERR: begin
                            n_idx = r_idx + 2'd1;
                            if (r_idx == 2'd2) begin
                                n_idx   = 2'd0;
                                n_state = ST_RATE;
                            end
                        end
                        ST_RATE: n_state = ST_HDT;
                        ST_HDT:  n_state = ST_SQ0;
                        ST_SQ0: begin
                            n_idx   = 2'd0;
                            n_state = ST_PQ;
                        end
                        ST_PQ: begin
                            n_idx = r_idx + 2'd1;
                            if (r_idx == 2'd3) begin
                                n_state = ST_SQ;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav[0] <= '0;
            r_grav[1] <= '0;
            r_grav[2] <= ONE_Q30;
            r_hdt     <= 31'd1073742;
            r_gain    <= 4'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRAV_X:  r_grav[0] <= i_cfg_data;
                CFG_GRAV_Y:  r_grav[1] <= i_cfg_data;
                CFG_GRAV_Z:  r_grav[2] <= i_cfg_data;
                CFG_HALF_DT: r_hdt     <= i_cfg_data[30:0];
                CFG_GAIN:    r_gain    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0]   <= ONE_Q30;
            r_q[1]   <= '0;
            r_q[2]   <= '0;
            r_q[3]   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_SQ && r_ph && r_vq && sq_zero) begin
                r_q[0] <= ONE_Q30;
                r_q[1] <= '0;
                r_q[2] <= '0;
                r_q[3] <= '0;
            end
            if (r_state == ST_UNIT && r_ph && r_vq) begin
                for (int i = 0; i < 4; i++) begin
                    r_q[i] <= f_sat32(mg_term[i]);
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= '{att_w: r_q[0], att_x: r_q[1], att_y: r_q[2], att_z: r_q[3]};
        end
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_acc[0]  <= i_in.accel_x;
                    r_acc[1]  <= i_in.accel_y;
                    r_acc[2]  <= i_in.accel_z;
                    r_rate[0] <= i_in.rate_x;
                    r_rate[1] <= i_in.rate_y;
                    r_rate[2] <= i_in.rate_z;
                    r_vq      <= 1'b0;
                end
            end
            ST_SQ: begin
                if (r_ph) begin
                    if (!sq_zero) begin
                        r_norm <= r_vq ? mg_sum[63:0] : {mg_sum[31:0], 32'd0};
                        r_c    <= r_vq ? 5'd0 : 5'd16;
                    end else if (!r_vq) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ua[i] <= '0;
                        end
                    end
                end
            end
            ST_NORM: begin
                if (r_norm[63:62] == 2'b00) begin
                    r_norm <= r_norm << 2;
                    r_c    <= r_c + 5'd1;
                end else begin
                    r_y  <= SEED[r_norm[63:61]];
                    r_nr <= '0;
                end
            end
            ST_NR1: begin
                if (r_ph) begin
                    r_y2 <= mg_term[0][32:0];
                end
            end
            ST_NR2: begin
                if (r_ph) begin
                    r_d <= nr_d;
                end
            end
            ST_NR3: begin
                if (r_ph) begin
                    r_y <= (nr_y > Y_MAX) ? Y_MAX[31:0] : nr_y[31:0];
                    if (r_nr != NR_LAST) begin
                        r_nr <= r_nr + 1'b1;
                    end
                end
            end
            ST_UNIT: begin
                if (r_ph && !r_vq) begin
                    for (int i = 0; i < 3; i++) begin
                        r_ua[i] <= f_sat32(mg_term[i]);
                    end
                end
            end
            ST_TQ: begin
                if (r_ph) begin
                    r_t[r_idx] <= f_sat32(mg_sum);
                end
            end
            ST_RQ: begin
                if (r_ph) begin
                    r_r[r_idx] <= f_sat32(mg_sum);
                end
            end
            ST_ERR: begin
                if (r_ph && r_idx != 2'd3) begin
                    r_err[r_idx] <= f_sat32(mg_sum);
                end
            end
            ST_RATE: begin
                if (r_ph) begin
                    for (int i = 0; i < 3; i++) begin
                        r_w[i] <= f_sat32(70'(r_rate[i]) + mg_term[i]);
                    end
                end
            end
            ST_HDT: begin
                if (r_ph) begin
                    for (int i = 0; i < 3; i++) begin
                        r_sq[i + 1] <= f_sat32(mg_term[i]);
                    end
                end
            end
            ST_SQ0: begin
                if (r_ph) begin
                    r_sq[0] <= f_sat32(70'sd1073741824 - (mg_sum >>> 1));
                end
            end
            ST_PQ: begin
                if (r_ph) begin
                    r_prod[r_idx] <= f_sat32(mg_sum);
                    if (r_idx == 2'd3) begin
                        r_vq <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SQ && !r_ph))
        else $error("Accepted item did not start the sum of squares.");

    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM) |-> (r_norm != 64'd0))
        else $error("Normalizing shift runs on a zero sum.");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NR1 || r_state == ST_UNIT) |-> (r_y <= Y_MAX[31:0]))
        else $error("Reciprocal root estimate exceeds 2.0.");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && o_out.att_w == $past(r_q[0])
                      && o_out.att_z == $past(r_q[3])))
        else $error("Finished attitude was not loaded into the output register.");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for quaternion_imu_fusion_step: drives accelerometer and gyro items,
// predicts each updated attitude with a fixed-point filter model and checks it.
// Depends on qif_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb import qif_pkg::*; ();

    localparam int NSTEPS = 3;
    localparam longint LMAX = 64'sd2147483647;
    localparam longint LMIN = -64'sd2147483648;

    class attitude_board;
        longint grav[3];
        longint hdt;
        longint kp;
        longint att[4];
        t_out_item pending[$];
        int errors;

        function new();
            grav[0] = 0;
            grav[1] = 0;
            grav[2] = 64'sd1073741824;
            hdt = 1073742;
            kp = 3;
            att[0] = 64'sd1073741824;
            att[1] = 0;
            att[2] = 0;
            att[3] = 0;
            errors = 0;
        endfunction

        function longint sat(longint v);
            if (v > LMAX) return LMAX;
            if (v < LMIN) return LMIN;
            return v;
        endfunction

        function longint fm(longint a, longint b, int s);
            longint unsigned ma;
            longint unsigned mb;
            longint unsigned r;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            r = (ma * mb) >> s;
            return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
        endfunction

        function void hamilton(longint a[4], longint b[4], output longint o[4]);
            o[0] = sat(fm(a[0], b[0], 30) - fm(a[1], b[1], 30) - fm(a[2], b[2], 30)
                       - fm(a[3], b[3], 30));
            o[1] = sat(fm(a[0], b[1], 30) + fm(a[1], b[0], 30) + fm(a[2], b[3], 30)
                       - fm(a[3], b[2], 30));
            o[2] = sat(fm(a[0], b[2], 30) + fm(a[2], b[0], 30) - fm(a[1], b[3], 30)
                       + fm(a[3], b[1], 30));
            o[3] = sat(fm(a[0], b[3], 30) + fm(a[3], b[0], 30) + fm(a[1], b[2], 30)
                       - fm(a[2], b[1], 30));
        endfunction

        function longint unsigned recip_root(longint unsigned m);
            longint unsigned y;
            longint unsigned y2;
            longint unsigned t;
            longint unsigned d;
            y = SEED[(m >> 29) & 7];
            for (int i = 0; i < NSTEPS; i++) begin
                y2 = (y * y) >> 30;
                t = (m * y2) >> 32;
                d = (t > 64'd3221225472) ? 0 : 64'd3221225472 - t;
                y = (y * d) >> 31;
                if (y > 64'h8000_0000) y = 64'h8000_0000;
            end
            return y;
        endfunction

        function bit to_unit(longint v[4], int n, int pre, output longint o[4]);
            longint unsigned s;
            longint unsigned u;
            longint unsigned m;
            longint unsigned y;
            longint unsigned r;
            int p;
            int e;
            int sh;
            s = 0;
            for (int i = 0; i < 4; i++) o[i] = 0;
            for (int i = 0; i < n; i++) begin
                u = v[i] < 0 ? -v[i] : v[i];
                s += (u * u) >> (2 * pre);
            end
            if (s == 0) return 0;
            p = 63;
            while (s[p] == 0) p--;
            e = (p % 2 == 0) ? p - 30 : p - 31;
            m = e >= 0 ? (s >> e) : (s << (-e));
            y = recip_root(m);
            sh = 16 + e / 2 + pre;
            for (int i = 0; i < n; i++) begin
                u = v[i] < 0 ? -v[i] : v[i];
                r = (sh >= 0 && sh < 64) ? ((u * y) >> sh) : 0;
                o[i] = sat(v[i] < 0 ? -longint'(r) : longint'(r));
            end
            return 1;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_GRAV_X: grav[0] = longint'(signed'(val));
                CFG_GRAV_Y: grav[1] = longint'(signed'(val));
                CFG_GRAV_Z: grav[2] = longint'(signed'(val));
                CFG_HALF_DT: hdt = val[30:0];
                CFG_GAIN: kp = val[3:0];
                default: ;
            endcase
        endfunction

        function void note_input(t_in_item it);
            longint acc[4];
            longint ua[4];
            longint rate[3];
            longint g[4];
            longint qc[4];
            longint t[4];
            longint r[4];
            longint err[3];
            longint sq[4];
            longint prod[4];
            longint nq[4];
            longint w;
            bit nz;
            t_out_item exp_q;
            acc[0] = it.accel_x;
            acc[1] = it.accel_y;
            acc[2] = it.accel_z;
            acc[3] = 0;
            rate[0] = it.rate_x;
            rate[1] = it.rate_y;
            rate[2] = it.rate_z;
            nz = to_unit(acc, 3, 0, ua);
            g[0] = 0;
            g[1] = grav[0];
            g[2] = grav[1];
            g[3] = grav[2];
            qc[0] = att[0];
            qc[1] = -att[1];
            qc[2] = -att[2];
            qc[3] = -att[3];
            hamilton(qc, g, t);
            hamilton(t, att, r);
            err[0] = sat(fm(ua[1], r[3], 30) - fm(ua[2], r[2], 30));
            err[1] = sat(fm(ua[2], r[1], 30) - fm(ua[0], r[3], 30));
            err[2] = sat(fm(ua[0], r[2], 30) - fm(ua[1], r[1], 30));
            for (int i = 0; i < 3; i++) begin
                w = sat(rate[i] + fm(err[i], kp, 6));
                sq[1 + i] = sat(fm(w, hdt, 25));
            end
            sq[0] = sat(64'sd1073741824 - ((fm(sq[1], sq[1], 30) + fm(sq[2], sq[2], 30)
                        + fm(sq[3], sq[3], 30)) >>> 1));
            hamilton(att, sq, prod);
            if (to_unit(prod, 4, 1, nq)) begin
                att = nq;
            end else begin
                att[0] = 64'sd1073741824;
                att[1] = 0;
                att[2] = 0;
                att[3] = 0;
            end
            exp_q.att_w = att[0][31:0];
            exp_q.att_x = att[1][31:0];
            exp_q.att_y = att[2][31:0];
            exp_q.att_z = att[3][31:0];
            pending.push_back(exp_q);
        endfunction

        function void check_output(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.att_w !== e.att_w)
                $display("%0t: att_w expected %h actual %h", $time, e.att_w, got.att_w);
            if (got.att_x !== e.att_x)
                $display("%0t: att_x expected %h actual %h", $time, e.att_x, got.att_x);
            if (got.att_y !== e.att_y)
                $display("%0t: att_y expected %h actual %h", $time, e.att_y, got.att_y);
            if (got.att_z !== e.att_z)
                $display("%0t: att_z expected %h actual %h", $time, e.att_z, got.att_z);
            if (got !== e) errors++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 0;
    t_out_item out_item;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    attitude_board board;
    int hold_off = 0;
    int stall_mode = 0;
    longint cycles = 0;

    always #2 clk = ~clk;

    quaternion_imu_fusion_step #(.NEWTON_STEPS(NSTEPS)) u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_output(out_item);
    end

    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 0;
        end else begin
            case (stall_mode)
                0: out_ready <= 1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(negedge clk) begin
        if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 2);
    end

    task automatic wait_drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic send_item(t_in_item it);
        in_valid <= 1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_input(it);
        @(negedge clk);
    endtask

    function automatic t_in_item rand_item(int kind);
        t_in_item it;
        it.accel_x = 16'($urandom);
        it.accel_y = 16'($urandom);
        it.accel_z = 16'($urandom);
        it.rate_x = $urandom;
        it.rate_y = $urandom;
        it.rate_z = $urandom;
        if (kind < 7) begin
            it.accel_x = 16'($signed($urandom_range(0, 4000)) - 2000);
            it.accel_y = 16'($signed($urandom_range(0, 4000)) - 2000);
            it.accel_z = 16'(16000 + $signed($urandom_range(0, 2000)));
            it.rate_x = $signed($urandom_range(0, 2 ** 26)) - 2 ** 25;
            it.rate_y = $signed($urandom_range(0, 2 ** 26)) - 2 ** 25;
            it.rate_z = $signed($urandom_range(0, 2 ** 26)) - 2 ** 25;
        end else if (kind == 7) begin
            it.accel_x = '0;
            it.accel_y = '0;
            if ($urandom_range(0, 1) != 0) it.accel_z = '0;
        end
        return it;
    endfunction

    task automatic random_phase(int n);
        int burst;
        for (int i = 0; i < n; i++) begin
            send_item(rand_item($urandom_range(0, 9)));
            burst--;
            if (burst <= 0) begin
                in_valid <= 0;
                repeat ($urandom_range(1, 40)) @(negedge clk);
                burst = $urandom_range(1, 20);
            end
        end
        in_valid <= 0;
    endtask

    initial begin
        t_in_item it;
        board = new();
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        it = '0;
        send_item(it);
        it.accel_x = 16'sh7fff; it.accel_y = 16'sh7fff; it.accel_z = 16'sh7fff;
        it.rate_x = 32'sh7fffffff; it.rate_y = 32'sh80000000; it.rate_z = 32'sh7fffffff;
        send_item(it);
        it.accel_x = 16'sh8000; it.accel_y = 16'sh8000; it.accel_z = 16'sh8000;
        it.rate_x = 32'sh80000000; it.rate_y = 32'sh7fffffff; it.rate_z = 32'sh80000000;
        send_item(it);
        it.accel_x = 16'sd1; it.accel_y = -16'sd1; it.accel_z = 16'sd0;
        it.rate_x = -32'sd1; it.rate_y = 32'sd1; it.rate_z = 32'sd0;
        send_item(it);
        for (int i = 0; i < 10; i++) send_item(rand_item(i % 10));
        in_valid <= 0;
        wait_drain();

        write_cfg(CFG_GAIN, 32'd15);
        write_cfg(CFG_HALF_DT, 32'h7fffffff);
        write_cfg(CFG_GRAV_X, 32'h7fffffff);
        write_cfg(CFG_GRAV_Y, 32'h80000000);
        write_cfg(CFG_GRAV_Z, 32'h80000000);
        for (int i = 0; i < 5; i++) send_item(rand_item(i * 2));
        in_valid <= 0;
        wait_drain();

        write_cfg(CFG_GAIN, 32'd0);
        write_cfg(CFG_HALF_DT, 32'd0);
        write_cfg(CFG_GRAV_X, 32'd0);
        write_cfg(CFG_GRAV_Y, 32'd0);
        write_cfg(CFG_GRAV_Z, 32'h40000000);
        hold_off = 600;
        random_phase(200);
        wait_drain();

        write_cfg(CFG_GAIN, 32'd3);
        write_cfg(CFG_HALF_DT, 32'd1073742);
        random_phase(700);
        wait_drain();

        for (int p = 0; p < 3; p++) begin
            write_cfg(CFG_GRAV_X, $urandom_range(0, 2 ** 20) - 2 ** 19);
            write_cfg(CFG_GRAV_Y, $urandom_range(0, 2 ** 20) - 2 ** 19);
            write_cfg(CFG_GRAV_Z, 32'h40000000 - $urandom_range(0, 2 ** 20));
            write_cfg(CFG_HALF_DT, $urandom_range(1, 2 ** 24));
            write_cfg(CFG_GAIN, $urandom_range(0, 15));
            random_phase(300);
            wait_drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
